// ----- hdl/assert_macros.svh -----
// assertion macros for the hdl folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(name, clk, rst, prop, msg)
`define ASSERT_NEVER(name, clk, rst, cond, msg)
`endif

`endif

// ----- hdl/irdla_pkg.sv -----
package irdla_pkg;

   localparam int VOLT_W   = 12;
   localparam int DIST_W   = 24;
   localparam int SUM_W    = 32;
   localparam int COUNT_W  = 8;
   localparam int GAIN_W   = 24;
   localparam int OFFSET_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int STEP_W   = $clog2(SUM_W);

   localparam logic [DIST_W-1:0]   DIST_MAX       = '1;
   localparam logic [COUNT_W-1:0]  COUNT_RESET    = 8'd1;
   localparam logic [GAIN_W-1:0]   GAIN_RESET     = 24'd2823091;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET   = 16'd30;

   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN         = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET       = 2'd2;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ----- hdl/irdla_div.sv -----
module irdla_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [irdla_pkg::SUM_W-1:0]     dividend,
   input  logic [irdla_pkg::VOLT_W-1:0]    divisor,
   output irdla_pkg::div_stat_type         stat,
   output logic [irdla_pkg::SUM_W-1:0]     quotient
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [irdla_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [irdla_pkg::SUM_W-1:0]      quot_ff, quot_in;
   logic [irdla_pkg::VOLT_W-1:0]     dsr_ff, dsr_in;
   logic [irdla_pkg::VOLT_W-1:0]     rem_ff, rem_in;
   logic [irdla_pkg::VOLT_W:0]       rem_sh;
   logic [irdla_pkg::VOLT_W:0]       rem_sub;
   logic                             fits;

   // one restoring step per cycle, quotient bits shift in behind the dividend
   always_comb begin
      rem_sh  = {rem_ff, quot_ff[irdla_pkg::SUM_W-1]};
      rem_sub = rem_sh - {1'b0, dsr_ff};
      fits    = (rem_sh >= {1'b0, dsr_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quot_in = quot_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '1;
         quot_in = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         quot_in = {quot_ff[irdla_pkg::SUM_W-2:0], fits};
         rem_in  = fits ? rem_sub[irdla_pkg::VOLT_W-1:0] : rem_sh[irdla_pkg::VOLT_W-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quot_ff <= quot_in;
      dsr_ff  <= dsr_in;
      rem_ff  <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quot_ff;

endmodule

// ----- hdl/ir_distance_linearize_average.sv -----
// channel  | handshake             | payload
// req      | req_valid/req_ready   | req_voltage_mv[11:0]
// rsp      | rsp_valid/rsp_ready   | rsp_average_distance_q8[23:0], rsp_saturated
// csr      | csr_valid/csr_ready   | csr_index[1:0], csr_wdata[23:0]
//
// a sample goes through accept, 32 steps of the shared divider, its done state and
// the accumulate state; a zero voltage skips the divider
// the sample that ends a run then computes the mean on the same divider
// a held result does not stop the next sample; only a second result waits for rsp_ready
// reset clears the run state and loads the register defaults; csr is always ready
`include "assert_macros.svh"

module ir_distance_linearize_average (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [irdla_pkg::VOLT_W-1:0]        req_voltage_mv,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [irdla_pkg::DIST_W-1:0]        rsp_average_distance_q8,
   output logic                                rsp_saturated,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [irdla_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [irdla_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LIN  = 3'd1;
   localparam logic [2:0] S_ACC  = 3'd2;
   localparam logic [2:0] S_AVG  = 3'd3;
   localparam logic [2:0] S_WAIT = 3'd4;

   logic [2:0]                          state_ff, state_in;
   logic [irdla_pkg::COUNT_W-1:0]       count_cfg_ff;
   logic [irdla_pkg::GAIN_W-1:0]        gain_cfg_ff;
   logic [irdla_pkg::OFFSET_W-1:0]      offset_cfg_ff;
   logic                                mv_zero_ff, mv_zero_in;
   logic [irdla_pkg::SUM_W-1:0]         sum_ff, sum_in;
   logic [irdla_pkg::COUNT_W-1:0]       taken_ff, taken_in;
   logic                                run_sat_ff, run_sat_in;
   logic                                end_sat_ff, end_sat_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [irdla_pkg::DIST_W-1:0]        avg_ff, avg_in;
   logic                                sat_out_ff, sat_out_in;

   logic                                div_start;
   logic [irdla_pkg::SUM_W-1:0]         div_dividend;
   logic [irdla_pkg::VOLT_W-1:0]        div_divisor;
   irdla_pkg::div_stat_type             div_stat;
   logic [irdla_pkg::SUM_W-1:0]         div_quot;

   logic                                req_fire;
   logic [irdla_pkg::DIST_W:0]          lin_sum;
   logic                                clip;
   logic [irdla_pkg::DIST_W-1:0]        lin_dist;
   logic [irdla_pkg::SUM_W-1:0]         new_sum;
   logic [irdla_pkg::COUNT_W:0]         taken_next;
   logic [irdla_pkg::COUNT_W:0]         run_len;
   logic                                end_run;
   logic                                load_out;

   irdla_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   assign req_fire = req_valid && req_ready;

   always_comb begin
      lin_sum = {{(irdla_pkg::DIST_W + 1 - irdla_pkg::OFFSET_W){1'b0}}, offset_cfg_ff}
              + {1'b0, div_quot[irdla_pkg::DIST_W-1:0]};
      clip    = mv_zero_ff || lin_sum[irdla_pkg::DIST_W];
      lin_dist = clip ? irdla_pkg::DIST_MAX : lin_sum[irdla_pkg::DIST_W-1:0];
      new_sum = sum_ff + {{(irdla_pkg::SUM_W - irdla_pkg::DIST_W){1'b0}}, lin_dist};
      taken_next = {1'b0, taken_ff} + 1'b1;
      run_len = (count_cfg_ff == '0) ? {{irdla_pkg::COUNT_W{1'b0}}, 1'b1}
                                     : {1'b0, count_cfg_ff};
      end_run = (taken_next >= run_len);
      load_out = ((state_ff == S_AVG && div_stat.done) || state_ff == S_WAIT)
               && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      state_in     = state_ff;
      mv_zero_in   = mv_zero_ff;
      sum_in       = sum_ff;
      taken_in     = taken_ff;
      run_sat_in   = run_sat_ff;
      end_sat_in   = end_sat_ff;
      avg_in       = avg_ff;
      sat_out_in   = sat_out_ff;
      rsp_valid_in = (rsp_valid_ff && !rsp_ready);
      div_start    = 1'b0;
      div_dividend = {{(irdla_pkg::SUM_W - irdla_pkg::GAIN_W){1'b0}}, gain_cfg_ff};
      div_divisor  = req_voltage_mv;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               mv_zero_in = (req_voltage_mv == '0);
               if (req_voltage_mv == '0) begin
                  state_in = S_ACC;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_LIN;
               end
            end
         end
         S_LIN: begin
            if (div_stat.done) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            if (end_run) begin
               div_start    = 1'b1;
               div_dividend = new_sum;
               div_divisor  = {{(irdla_pkg::VOLT_W - irdla_pkg::COUNT_W){1'b0}},
                               taken_next[irdla_pkg::COUNT_W-1:0]};
               end_sat_in   = run_sat_ff || clip;
               sum_in       = '0;
               taken_in     = '0;
               run_sat_in   = 1'b0;
               state_in     = S_AVG;
            end else begin
               sum_in     = new_sum;
               taken_in   = taken_next[irdla_pkg::COUNT_W-1:0];
               run_sat_in = run_sat_ff || clip;
               state_in   = S_IDLE;
            end
         end
         S_AVG: begin
            if (div_stat.done) begin
               state_in = load_out ? S_IDLE : S_WAIT;
            end
         end
         S_WAIT: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (load_out) begin
         rsp_valid_in = 1'b1;
         avg_in       = div_quot[irdla_pkg::DIST_W-1:0];
         sat_out_in   = end_sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         sum_ff        <= '0;
         taken_ff      <= '0;
         run_sat_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         count_cfg_ff  <= irdla_pkg::COUNT_RESET;
         gain_cfg_ff   <= irdla_pkg::GAIN_RESET;
         offset_cfg_ff <= irdla_pkg::OFFSET_RESET;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         taken_ff     <= taken_in;
         run_sat_ff   <= run_sat_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               irdla_pkg::REG_SAMPLE_COUNT: count_cfg_ff <= csr_wdata[irdla_pkg::COUNT_W-1:0];
               irdla_pkg::REG_GAIN:         gain_cfg_ff  <= csr_wdata[irdla_pkg::GAIN_W-1:0];
               irdla_pkg::REG_OFFSET:    offset_cfg_ff <= csr_wdata[irdla_pkg::OFFSET_W-1:0];
               default: begin
               end
            endcase
         end
      end
      mv_zero_ff <= mv_zero_in;
      end_sat_ff <= end_sat_in;
      avg_ff     <= avg_in;
      sat_out_ff <= sat_out_in;
   end

   assign req_ready               = (state_ff == S_IDLE);
   assign csr_ready               = 1'b1;
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_average_distance_q8 = avg_ff;
   assign rsp_saturated           = sat_out_ff;

   `ASSERT_PROP(a_lin_div_busy, clock, reset, (state_ff == S_LIN) |-> (div_stat.busy || div_stat.done), "divider idle while linearizing")
   `ASSERT_NEVER(a_done_stray, clock, reset, div_stat.done && !(state_ff == S_LIN || state_ff == S_AVG), "divider done outside a divide state")
   `ASSERT_NEVER(a_taken_range, clock, reset, taken_ff == '1, "sample counter past run limit")
   `ASSERT_PROP(a_rsp_drain, clock, reset, (rsp_valid_ff && rsp_ready && !load_out) |=> !rsp_valid_ff, "result word not released")

endmodule

// ----- dv/tb_ir_distance_linearize_average.sv -----
`timescale 1ns / 100ps

module tb_ir_distance_linearize_average;
   import irdla_pkg::*;

   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int SETTLE_CYCLES = 80;
   localparam int PHASES = 8;
   localparam int WORDS_PER_PHASE = 92;
   localparam int HEAVY_PCT = 87;
   localparam int LIGHT_PCT = 15;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              sat;
   } mean_type;

   typedef struct {
      bit                    is_write;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] wdata;
      logic [VOLT_W-1:0]     mv;
      bit                    typed;
      logic [DIST_W-1:0]     distance;
      logic                  sat;
   } step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [VOLT_W-1:0] req_voltage_mv = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [DIST_W-1:0] rsp_average_distance_q8;
   logic rsp_saturated;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state
   logic [COUNT_W-1:0]  cfg_count = COUNT_RESET;
   logic [GAIN_W-1:0]   cfg_gain = GAIN_RESET;
   logic [OFFSET_W-1:0] cfg_offset = OFFSET_RESET;
   logic [SUM_W-1:0]    run_sum = '0;
   logic [COUNT_W-1:0]  run_len = '0;
   logic                run_sat = 1'b0;

   mean_type pending_means[$];
   mean_type got_mean;
   step_type directed_steps[$];
   int    error_count = 0;
   int    cycle_count = 0;
   int    idle_pct = 0;
   int    stall_pct = 0;

   ir_distance_linearize_average u_top (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_voltage_mv          (req_voltage_mv),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_average_distance_q8 (rsp_average_distance_q8),
      .rsp_saturated           (rsp_saturated),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(0, 99) >= stall_pct);
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_means.size() == 0) begin
            report_mismatch($sformatf("result word %0h/%0b with none expected",
                                      rsp_average_distance_q8, rsp_saturated));
         end else begin
            got_mean = pending_means.pop_front();
            if (rsp_average_distance_q8 !== got_mean.distance)
               report_mismatch($sformatf("average_distance_q8 %0h, expected %0h",
                                         rsp_average_distance_q8, got_mean.distance));
            if (rsp_saturated !== got_mean.sat)
               report_mismatch($sformatf("saturated %0b, expected %0b",
                                         rsp_saturated, got_mean.sat));
         end
      end
   end

   // distance of one sample folded into the running mean
   function automatic bit accumulate_distance(input logic [VOLT_W-1:0] mv,
                                              output mean_type mean);
      logic [SUM_W-1:0]   wide;
      logic [DIST_W-1:0]  sample_distance;
      logic               clipped;
      logic [COUNT_W:0]   taken;
      logic [COUNT_W:0]   needed;
      if (mv == '0) begin
         sample_distance = DIST_MAX;
         clipped = 1'b1;
      end else begin
         wide = SUM_W'(cfg_offset) + SUM_W'(cfg_gain) / SUM_W'(mv);
         clipped = wide > SUM_W'(DIST_MAX);
         sample_distance = clipped ? DIST_MAX : wide[DIST_W-1:0];
      end
      run_sum = run_sum + SUM_W'(sample_distance);
      run_sat = run_sat | clipped;
      taken = {1'b0, run_len} + 1'b1;
      needed = (cfg_count == '0) ? {{COUNT_W{1'b0}}, 1'b1} : {1'b0, cfg_count};
      mean = '0;
      if (taken >= needed) begin
         wide = run_sum / SUM_W'(taken);
         mean.distance = wide[DIST_W-1:0];
         mean.sat = run_sat;
         run_sum = '0;
         run_len = '0;
         run_sat = 1'b0;
         return 1'b1;
      end
      run_len = taken[COUNT_W-1:0];
      return 1'b0;
   endfunction

   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] index,
                                     input logic [CSR_DATA_W-1:0] data);
      case (index)
         REG_SAMPLE_COUNT: cfg_count = data[COUNT_W-1:0];
         REG_GAIN:         cfg_gain = data[GAIN_W-1:0];
         REG_OFFSET:       cfg_offset = data[OFFSET_W-1:0];
         default: begin
         end
      endcase
   endfunction

   // csr_valid is left high; the caller lowers it after the last write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_reg(index, data);
   endtask

   task automatic send_sample(input logic [VOLT_W-1:0] mv, input bit typed,
                              input logic [DIST_W-1:0] distance, input logic sat);
      mean_type mean;
      while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_voltage_mv <= mv;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (accumulate_distance(mv, mean)) begin
         if (typed) begin
            mean.distance = distance;
            mean.sat = sat;
         end
         pending_means.push_back(mean);
      end
   endtask

   // block quiet: every mean taken and any sample without a result finished
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (pending_means.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic step_type cfg_row(input logic [CSR_IDX_W-1:0] index,
                                        input logic [CSR_DATA_W-1:0] data);
      step_type s;
      s = '{1'b1, index, data, '0, 1'b0, '0, 1'b0};
      return s;
   endfunction

   function automatic step_type mv_row(input logic [VOLT_W-1:0] mv, input bit typed,
                                       input logic [DIST_W-1:0] distance,
                                       input logic sat);
      step_type s;
      s = '{1'b0, '0, '0, mv, typed, distance, sat};
      return s;
   endfunction

   function automatic logic [VOLT_W-1:0] draw_voltage();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) return '0;
      if (pick < 16) return VOLT_W'($urandom_range(1, 4));
      return VOLT_W'($urandom_range(0, (1 << VOLT_W) - 1));
   endfunction

   initial begin
      logic [COUNT_W-1:0]  count;
      logic [GAIN_W-1:0]   gain;
      logic [OFFSET_W-1:0] offset;
      bit                  prev_write;

      // register defaults after reset
      directed_steps.push_back(mv_row(12'd0, 1'b1, DIST_MAX, 1'b1));
      directed_steps.push_back(mv_row(12'd4095, 1'b1, 24'd719, 1'b0));
      directed_steps.push_back(mv_row(12'd1, 1'b1, 24'd2823121, 1'b0));
      directed_steps.push_back(mv_row(12'h800, 1'b0, '0, 1'b0));
      directed_steps.push_back(mv_row(12'h555, 1'b0, '0, 1'b0));
      directed_steps.push_back(mv_row(12'hAAA, 1'b0, '0, 1'b0));
      // largest gain and offset: clipping
      directed_steps.push_back(cfg_row(REG_GAIN, 24'hFFFFFF));
      directed_steps.push_back(cfg_row(REG_OFFSET, 24'hFFFFFF));
      directed_steps.push_back(mv_row(12'd1, 1'b1, DIST_MAX, 1'b1));
      directed_steps.push_back(mv_row(12'd4095, 1'b0, '0, 1'b0));
      directed_steps.push_back(mv_row(12'd2, 1'b0, '0, 1'b0));
      // zero gain and offset
      directed_steps.push_back(cfg_row(REG_GAIN, 24'd0));
      directed_steps.push_back(cfg_row(REG_OFFSET, 24'd0));
      directed_steps.push_back(mv_row(12'd4095, 1'b1, 24'd0, 1'b0));
      directed_steps.push_back(mv_row(12'd0, 1'b1, DIST_MAX, 1'b1));
      // count of zero acts as one
      directed_steps.push_back(cfg_row(REG_SAMPLE_COUNT, 24'hABCD00));
      directed_steps.push_back(cfg_row(REG_GAIN, GAIN_RESET));
      directed_steps.push_back(cfg_row(REG_OFFSET, CSR_DATA_W'(OFFSET_RESET)));
      directed_steps.push_back(mv_row(12'd300, 1'b0, '0, 1'b0));
      directed_steps.push_back(mv_row(12'd0, 1'b1, DIST_MAX, 1'b1));
      // count lowered mid-run, sticky flag, unused index
      directed_steps.push_back(cfg_row(REG_SAMPLE_COUNT, 24'd4));
      directed_steps.push_back(mv_row(12'd1000, 1'b0, '0, 1'b0));
      directed_steps.push_back(mv_row(12'd0, 1'b0, '0, 1'b0));
      directed_steps.push_back(mv_row(12'd2000, 1'b0, '0, 1'b0));
      directed_steps.push_back(cfg_row(REG_SAMPLE_COUNT, 24'd2));
      directed_steps.push_back(cfg_row(REG_UNUSED, 24'h5A5A5A));
      directed_steps.push_back(mv_row(12'd3000, 1'b0, '0, 1'b0));
      directed_steps.push_back(mv_row(12'd500, 1'b0, '0, 1'b0));
      directed_steps.push_back(mv_row(12'd4095, 1'b0, '0, 1'b0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      prev_write = 1'b0;
      foreach (directed_steps[i]) begin
         if (directed_steps[i].is_write) begin
            if (!prev_write) wait_for_idle();
            write_reg(directed_steps[i].index, directed_steps[i].wdata);
            if (i + 1 >= directed_steps.size() || !directed_steps[i + 1].is_write)
               csr_valid <= 1'b0;
         end else begin
            send_sample(directed_steps[i].mv, directed_steps[i].typed,
                        directed_steps[i].distance, directed_steps[i].sat);
         end
         prev_write = directed_steps[i].is_write;
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_for_idle();
         case (phase)
            2:       count = '0;
            3:       count = 8'd255;
            5:       count = 8'd1;
            default: count = COUNT_W'($urandom_range(1, 12));
         endcase
         case (phase)
            3: begin
               gain = '1;
               offset = '1;
            end
            6: begin
               gain = '0;
               offset = '0;
            end
            default: begin
               gain = (phase % 2 == 1) ? GAIN_W'($urandom)
                                       : GAIN_W'($urandom_range(1000, 4_000_000));
               offset = OFFSET_W'($urandom);
            end
         endcase
         write_reg(REG_OFFSET, {8'($urandom), offset});
         write_reg(REG_UNUSED, 24'($urandom));
         write_reg(REG_GAIN, gain);
         write_reg(REG_SAMPLE_COUNT, {16'($urandom), count});
         csr_valid <= 1'b0;
         case (phase % 4)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct = HEAVY_PCT;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = HEAVY_PCT;
            end
            default: begin
               idle_pct = LIGHT_PCT;
               stall_pct = LIGHT_PCT;
            end
         endcase
         for (int n = 0; n < WORDS_PER_PHASE; n++)
            send_sample(draw_voltage(), 1'b0, '0, 1'b0);
      end

      wait_for_idle();
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
